// ===== sv/slde_pkg.sv =====
// Shared types and constants of the sync/length/end-sign deframer.
package slde_pkg;

    // Defaults for the top-level parameters.
    localparam int CHANNELS_DEF      = 2;
    localparam int BUFFER_DEPTH_DEF  = 64;
    localparam int MIN_FRAME_DEF     = 4;
    localparam int LENGTH_OFFSET_DEF = 1;

    // Configuration register reset values.
    localparam logic [6:0] MAX_FRAME_LEN_RST = 7'd64;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_SIGN    = 2'd0,
        CFG_END_SIGN      = 2'd1,
        CFG_MAX_FRAME_LEN = 2'd2
    } cfg_index_t;

    // Read position selection of the datapath.
    typedef enum logic [1:0] {
        RD_OFF = 2'd0,
        RD_LO  = 2'd1,
        RD_HI  = 2'd2,
        RD_END = 2'd3
    } rd_base_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_LEN_CHK,
        ST_END,
        ST_EMIT_ADDR,
        ST_EMIT_DATA,
        ST_DONE_CHK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     use_idx;
        rd_base_t rd_base;
        logic     skip;
        logic     load_lo;
        logic     load_len;
        logic     idx_clear;
        logic     emit_next;
        logic     consume;
        logic     copy_write;
        logic     finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_ch_ok;
        logic remain_lt_min;
        logic off_zero;
        logic remain_zero;
        logic start_match;
        logic len_ok;
        logic len_wait;
        logic end_match;
        logic emit_last;
        logic copy_last;
    } status_t;

endpackage

// ===== sv/sync_length_end_deframer.sv =====
// Top level of the sync/length/end-sign deframer.
//
// Each accepted byte is appended to the buffer of its channel (dropped if
// that buffer is full, ignored if the channel has no buffer), and the buffer
// is then rescanned from its head for frames that open with start_sign, carry
// a little-endian 16-bit length at LENGTH_OFFSET and close with end_sign.
// Each good frame is sent out byte by byte; a bad candidate skips one byte.
// All work goes through one buffer memory with a single read port and a
// registered read: each skipped byte, checked candidate and emitted byte
// needs its own reads, an emitted byte also waits out any output stall, and
// after the scan the remaining bytes are moved to the head of the buffer one
// by one. The input is ready again only when all of this has finished.
module sync_length_end_deframer #(
    parameter int CHANNELS      = slde_pkg::CHANNELS_DEF,
    parameter int BUFFER_DEPTH  = slde_pkg::BUFFER_DEPTH_DEF,
    parameter int MIN_FRAME     = slde_pkg::MIN_FRAME_DEF,
    parameter int LENGTH_OFFSET = slde_pkg::LENGTH_OFFSET_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_channel,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_channel,
    output logic [7:0] m_frame_byte,
    output logic [6:0] m_frame_length,
    output logic       m_byte_last
);

    slde_pkg::cmd_t    cmd;
    slde_pkg::status_t status;

    // Sequencing.
    slde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Buffer and compare logic.
    slde_dp #(
        .CHANNELS      (CHANNELS),
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .MIN_FRAME     (MIN_FRAME),
        .LENGTH_OFFSET (LENGTH_OFFSET)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_channel      (s_channel),
        .s_data_byte    (s_data_byte),
        .m_out_channel  (m_out_channel),
        .m_frame_byte   (m_frame_byte),
        .m_frame_length (m_frame_length),
        .m_byte_last    (m_byte_last),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ===== sv/slde_ctrl.sv =====
// Controller state machine of the deframer: scan, emit and compaction sequencing.
module slde_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  slde_pkg::status_t status,
    output slde_pkg::cmd_t    cmd
);

    slde_pkg::state_t state_reg;
    slde_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slde_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slde_pkg::ST_IDLE: begin
                if (s_valid && status.in_ch_ok) state_next = slde_pkg::ST_SCAN;
            end
            slde_pkg::ST_SCAN: begin
                if (status.remain_lt_min) state_next = slde_pkg::ST_DONE_CHK;
                else state_next = slde_pkg::ST_START;
            end
            slde_pkg::ST_START: begin
                if (status.start_match) state_next = slde_pkg::ST_LEN_LO;
                else state_next = slde_pkg::ST_SCAN;
            end
            slde_pkg::ST_LEN_LO: state_next = slde_pkg::ST_LEN_HI;
            slde_pkg::ST_LEN_HI: state_next = slde_pkg::ST_LEN_CHK;
            slde_pkg::ST_LEN_CHK: begin
                if (!status.len_ok) state_next = slde_pkg::ST_SCAN;
                else if (status.len_wait) state_next = slde_pkg::ST_DONE_CHK;
                else state_next = slde_pkg::ST_END;
            end
            slde_pkg::ST_END: begin
                if (status.end_match) state_next = slde_pkg::ST_EMIT_ADDR;
                else state_next = slde_pkg::ST_SCAN;
            end
            slde_pkg::ST_EMIT_ADDR: state_next = slde_pkg::ST_EMIT_DATA;
            slde_pkg::ST_EMIT_DATA: begin
                if (m_ready) begin
                    if (status.emit_last) state_next = slde_pkg::ST_SCAN;
                    else state_next = slde_pkg::ST_EMIT_ADDR;
                end
            end
            slde_pkg::ST_DONE_CHK: begin
                if (status.off_zero || status.remain_zero) state_next = slde_pkg::ST_FINISH;
                else state_next = slde_pkg::ST_COPY_RD;
            end
            slde_pkg::ST_COPY_RD: state_next = slde_pkg::ST_COPY_WR;
            slde_pkg::ST_COPY_WR: begin
                if (status.copy_last) state_next = slde_pkg::ST_FINISH;
                else state_next = slde_pkg::ST_COPY_RD;
            end
            slde_pkg::ST_FINISH: state_next = slde_pkg::ST_IDLE;
            default: state_next = slde_pkg::ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            slde_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            slde_pkg::ST_SCAN: begin
                cmd.rd_base = slde_pkg::RD_OFF;
            end
            slde_pkg::ST_START: begin
                cmd.skip    = !status.start_match;
                cmd.rd_base = slde_pkg::RD_LO;
            end
            slde_pkg::ST_LEN_LO: begin
                cmd.load_lo = 1'b1;
                cmd.rd_base = slde_pkg::RD_HI;
            end
            slde_pkg::ST_LEN_HI: begin
                cmd.load_len = 1'b1;
            end
            slde_pkg::ST_LEN_CHK: begin
                cmd.skip    = !status.len_ok;
                cmd.rd_base = slde_pkg::RD_END;
            end
            slde_pkg::ST_END: begin
                cmd.skip      = !status.end_match;
                cmd.idx_clear = status.end_match;
            end
            slde_pkg::ST_EMIT_ADDR: begin
                cmd.use_idx = 1'b1;
            end
            slde_pkg::ST_EMIT_DATA: begin
                m_valid       = 1'b1;
                cmd.use_idx   = 1'b1;
                cmd.emit_next = m_ready && !status.emit_last;
                cmd.consume   = m_ready && status.emit_last;
            end
            slde_pkg::ST_DONE_CHK: begin
                cmd.idx_clear = 1'b1;
            end
            slde_pkg::ST_COPY_RD: begin
                cmd.use_idx = 1'b1;
            end
            slde_pkg::ST_COPY_WR: begin
                cmd.copy_write = 1'b1;
            end
            slde_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/slde_dp.sv =====
// Datapath of the deframer: configuration, byte buffer memory, counters and compares.
module slde_dp #(
    parameter int CHANNELS      = slde_pkg::CHANNELS_DEF,
    parameter int BUFFER_DEPTH  = slde_pkg::BUFFER_DEPTH_DEF,
    parameter int MIN_FRAME     = slde_pkg::MIN_FRAME_DEF,
    parameter int LENGTH_OFFSET = slde_pkg::LENGTH_OFFSET_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic              s_channel,
    input  logic [7:0]        s_data_byte,
    output logic              m_out_channel,
    output logic [7:0]        m_frame_byte,
    output logic [6:0]        m_frame_length,
    output logic              m_byte_last,
    input  slde_pkg::cmd_t    cmd,
    output slde_pkg::status_t status
);

    localparam int CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
    localparam int POS_W     = $clog2(2 * BUFFER_DEPTH + LENGTH_OFFSET + 2);
    localparam int MEM_DEPTH = CHANNELS * BUFFER_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    // Configuration registers.
    logic [7:0] start_sign_reg;
    logic [7:0] end_sign_reg;
    logic [6:0] max_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_sign_reg <= 8'd0;
            end_sign_reg   <= 8'd0;
            max_len_reg    <= slde_pkg::MAX_FRAME_LEN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                slde_pkg::CFG_START_SIGN:    start_sign_reg <= cfg_wdata;
                slde_pkg::CFG_END_SIGN:      end_sign_reg   <= cfg_wdata;
                slde_pkg::CFG_MAX_FRAME_LEN: max_len_reg    <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Scan state registers.
    logic             ch_reg;
    logic [CNT_W-1:0] off_reg;
    logic [CNT_W-1:0] remain_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [7:0]       lo_reg;
    logic [15:0]      len_reg;
    logic [CNT_W-1:0] fill_reg [CHANNELS];

    logic [7:0]    mem [MEM_DEPTH];
    logic [7:0]    mem_q;
    logic          oob_q;
    logic [7:0]    rdata;
    logic [CNT_W-1:0] fill_in;
    logic          in_full;
    logic [CNT_W-1:0] fill_cur;
    logic [POS_W-1:0] pos;
    logic          oob;
    logic [AW-1:0] ch_base;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;
    logic [15:0]   len_new;

    assign fill_in  = fill_reg[CW'(s_channel)];
    assign fill_cur = fill_reg[CW'(ch_reg)];
    assign in_full  = (fill_in == CNT_W'(BUFFER_DEPTH));
    assign ch_base  = AW'(ch_reg) * AW'(BUFFER_DEPTH);
    assign rdata    = oob_q ? 8'h00 : mem_q;
    assign len_new  = {rdata, lo_reg};

    // Read position for the next memory read.
    always_comb begin
        if (cmd.use_idx) begin
            pos = POS_W'(off_reg) + POS_W'(idx_reg);
        end else begin
            case (cmd.rd_base)
                slde_pkg::RD_OFF: pos = POS_W'(off_reg);
                slde_pkg::RD_LO:  pos = POS_W'(off_reg) + POS_W'(LENGTH_OFFSET);
                slde_pkg::RD_HI:  pos = POS_W'(off_reg) + POS_W'(LENGTH_OFFSET + 1);
                slde_pkg::RD_END: pos = POS_W'(off_reg) + POS_W'(len_reg[CNT_W-1:0])
                                        - POS_W'(1);
                default:          pos = POS_W'(off_reg);
            endcase
        end
    end

    assign oob     = (pos >= POS_W'(BUFFER_DEPTH));
    assign rd_addr = ch_base + (oob ? AW'(0) : AW'(pos));

    // Write port source: arriving byte or compaction copy.
    always_comb begin
        if (cmd.copy_write) begin
            wr_en   = 1'b1;
            wr_addr = ch_base + AW'(idx_reg);
            wr_data = rdata;
        end else begin
            wr_en   = cmd.accept && status.in_ch_ok && !in_full;
            wr_addr = AW'(s_channel) * AW'(BUFFER_DEPTH) + AW'(fill_in);
            wr_data = s_data_byte;
        end
    end

    // Buffer memory with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
        oob_q <= oob;
    end

    // Offset, remaining count, index, channel and fill counts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg    <= '0;
            remain_reg <= '0;
            idx_reg    <= '0;
            ch_reg     <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                fill_reg[c] <= '0;
            end
        end else begin
            if (cmd.accept && status.in_ch_ok) begin
                ch_reg     <= s_channel;
                off_reg    <= '0;
                remain_reg <= in_full ? fill_in : fill_in + CNT_W'(1);
            end
            if (cmd.skip) begin
                off_reg    <= off_reg + CNT_W'(1);
                remain_reg <= remain_reg - CNT_W'(1);
            end
            if (cmd.consume) begin
                off_reg    <= off_reg + len_reg[CNT_W-1:0];
                remain_reg <= remain_reg - len_reg[CNT_W-1:0];
            end
            if (cmd.idx_clear) idx_reg <= '0;
            if (cmd.emit_next || cmd.copy_write) idx_reg <= idx_reg + CNT_W'(1);
            if (cmd.finish) fill_reg[CW'(ch_reg)] <= remain_reg;
        end
    end

    // Length capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_lo) lo_reg <= rdata;
        if (cmd.load_len) len_reg <= len_new;
    end

    // Status toward the controller.
    always_comb begin
        status.in_ch_ok      = (32'(s_channel) < 32'(CHANNELS));
        status.remain_lt_min = (32'(remain_reg) < 32'(MIN_FRAME));
        status.off_zero      = (off_reg == '0);
        status.remain_zero   = (remain_reg == '0);
        status.start_match   = (rdata == start_sign_reg);
        status.len_ok        = (len_reg >= 16'(MIN_FRAME)) && (len_reg <= 16'(max_len_reg))
                               && (len_reg <= 16'(BUFFER_DEPTH));
        status.len_wait      = (16'(remain_reg) < len_reg);
        status.end_match     = (rdata == end_sign_reg);
        status.emit_last     = (16'(idx_reg) == len_reg - 16'd1);
        status.copy_last     = ((idx_reg + CNT_W'(1)) == remain_reg);
    end

    // Result payload.
    assign m_out_channel  = ch_reg;
    assign m_frame_byte   = rdata;
    assign m_frame_length = len_reg[6:0];
    assign m_byte_last    = status.emit_last;

    // The scan window never runs past the buffer.
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(off_reg) + 32'(remain_reg)) <= 32'(BUFFER_DEPTH))
        else $error("scan window exceeds buffer");

    // A compaction write stays inside the remaining bytes.
    a_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy_write |-> (idx_reg < remain_reg) && !oob_q)
        else $error("compaction write out of range");

    // Consuming a frame removes no more bytes than are buffered.
    a_consume: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.consume |-> (len_reg <= 16'(remain_reg)))
        else $error("frame longer than remaining bytes");

    // A stored fill count never exceeds the buffer depth.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (fill_cur <= CNT_W'(BUFFER_DEPTH)))
        else $error("fill count exceeds buffer depth");

endmodule

// ===== tb/sv/sync_length_end_deframer_tb.sv =====
// Self-checking testbench of the sync/length/end-sign deframer.
module sync_length_end_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH       = 2;
    localparam int DEPTH     = 64;
    localparam int MINLEN    = 4;
    localparam int LOFF      = 1;
    localparam int IDLE_WAIT = 600;
    localparam int STALL_MAX = 6000;

    typedef struct {
        logic       ch;
        logic [7:0] data;
    } byte_item_t;

    typedef struct {
        logic       ch;
        logic [7:0] data;
        logic [6:0] len;
        logic       last;
    } frame_beat_t;

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       cfg_we = 0;
    logic [1:0] cfg_index = slde_pkg::CFG_START_SIGN;
    logic [7:0] cfg_wdata = 0;
    logic       s_valid = 0;
    logic       s_ready;
    logic       s_channel = 0;
    logic [7:0] s_data_byte = 0;
    logic       m_valid;
    logic       m_ready = 0;
    logic       m_out_channel;
    logic [7:0] m_frame_byte;
    logic [6:0] m_frame_length;
    logic       m_byte_last;

    sync_length_end_deframer dut (.*);

    // Stimulus queue, expected frame beats and the mirror of the block.
    byte_item_t  pending_bytes[$];
    frame_beat_t expected_beats[$];
    logic [7:0]  mirror_buf[NCH][DEPTH];
    int          mirror_fill[NCH];
    logic [7:0]  mir_start = 8'd0;
    logic [7:0]  mir_end = 8'd0;
    logic [6:0]  mir_max = slde_pkg::MAX_FRAME_LEN_RST;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit in_taken = 0;
    bit hold_req = 0;
    int hold_cnt = 0;
    int errors = 0;
    int quiet_cycles = 0;

    initial forever #4 aclk = ~aclk;

    // Deframe one accepted byte and queue the frame beats it releases.
    task automatic deframe_byte(input logic ch, input logic [7:0] b);
        int off;
        int remain;
        int flen;
        bit done;
        frame_beat_t fb;
        off = 0;
        done = 0;
        if (mirror_fill[ch] < DEPTH) begin
            mirror_buf[ch][mirror_fill[ch]] = b;
            mirror_fill[ch]++;
        end
        remain = mirror_fill[ch];
        while (remain >= MINLEN && !done) begin
            if (mirror_buf[ch][off] == mir_start) begin
                flen = mirror_buf[ch][off + LOFF] + 256 * mirror_buf[ch][off + LOFF + 1];
                if (flen >= MINLEN && flen <= mir_max && flen <= DEPTH) begin
                    if (remain < flen) begin
                        done = 1;
                    end else if (mirror_buf[ch][off + flen - 1] == mir_end) begin
                        for (int i = 0; i < flen; i++) begin
                            fb.ch = ch;
                            fb.data = mirror_buf[ch][off + i];
                            fb.len = flen[6:0];
                            fb.last = (i == flen - 1);
                            expected_beats.push_back(fb);
                        end
                        off += flen;
                        remain -= flen;
                        continue;
                    end
                end
            end
            if (!done) begin
                off++;
                remain--;
            end
        end
        for (int i = 0; i < remain; i++) mirror_buf[ch][i] = mirror_buf[ch][off + i];
        mirror_fill[ch] = remain;
    endtask

    // Check result transfers, track input transfers and configuration writes.
    always @(posedge aclk) begin
        frame_beat_t exp_b;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected frame byte %0h", m_frame_byte);
                    errors++;
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (m_out_channel !== exp_b.ch) begin
                        $error("out_channel exp %0h got %0h", exp_b.ch, m_out_channel);
                        errors++;
                    end
                    if (m_frame_byte !== exp_b.data) begin
                        $error("frame_byte exp %0h got %0h", exp_b.data, m_frame_byte);
                        errors++;
                    end
                    if (m_frame_length !== exp_b.len) begin
                        $error("frame_length exp %0d got %0d", exp_b.len, m_frame_length);
                        errors++;
                    end
                    if (m_byte_last !== exp_b.last) begin
                        $error("byte_last exp %0h got %0h", exp_b.last, m_byte_last);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                deframe_byte(s_channel, s_data_byte);
                in_taken = 1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    slde_pkg::CFG_START_SIGN:    mir_start = cfg_wdata;
                    slde_pkg::CFG_END_SIGN:      mir_end = cfg_wdata;
                    slde_pkg::CFG_MAX_FRAME_LEN: mir_max = cfg_wdata[6:0];
                    default: ;
                endcase
            end
            // Watchdog on cycles with no transfer and no configuration write.
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Sender: present queued bytes, with random idle cycles.
    always @(negedge aclk) begin
        byte_item_t it;
        if (!s_valid || in_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_bytes.pop_front();
                s_channel <= it.ch;
                s_data_byte <= it.data;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        in_taken = 0;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_req && hold_cnt == 0) hold_cnt = 400;
        if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) hold_req = 0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_byte(input logic ch, input logic [7:0] b);
        byte_item_t it;
        it.ch = ch;
        it.data = b;
        pending_bytes.push_back(it);
    endtask

    // Queue a frame on one channel, with stray bytes on the other in between.
    task automatic push_frame(input logic ch, input int flen, input bit good_end,
                              input logic [7:0] st, input logic [7:0] en);
        logic [7:0] b;
        for (int i = 0; i < flen; i++) begin
            if (i == 0) b = st;
            else if (i == LOFF) b = flen[7:0];
            else if (i == LOFF + 1) b = flen[15:8];
            else if (i == flen - 1) b = good_end ? en : ~en;
            else b = 8'($urandom_range(255));
            if ($urandom_range(99) < 8) push_byte(~ch, 8'($urandom_range(255)));
            push_byte(ch, b);
        end
    endtask

    task automatic write_reg(input slde_pkg::cfg_index_t idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Wait until the block is idle, then let its rescan settle.
    task automatic drain;
        while (pending_bytes.size() != 0 || s_valid || expected_beats.size() != 0)
            @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
    endtask

    task automatic set_signs(input logic [7:0] st, input logic [7:0] en,
                             input logic [6:0] mx);
        write_reg(slde_pkg::CFG_START_SIGN, st);
        write_reg(slde_pkg::CFG_END_SIGN, en);
        write_reg(slde_pkg::CFG_MAX_FRAME_LEN, {1'b0, mx});
    endtask

    // Random frames of mostly small size, some broken, some noise.
    task automatic push_random(input int nbytes, input logic [7:0] st,
                               input logic [7:0] en, input int mx);
        int target;
        int pick;
        int flen;
        logic ch;
        target = pending_bytes.size() + nbytes;
        while (pending_bytes.size() < target) begin
            pick = $urandom_range(99);
            flen = ($urandom_range(9) == 0) ? $urandom_range(MINLEN, (mx < 16) ? mx : 16)
                                            : $urandom_range(MINLEN, (mx < 10) ? mx : 10);
            ch = 1'($urandom_range(1));
            if (pick < 65) push_frame(ch, flen, 1, st, en);
            else if (pick < 80) push_frame(ch, flen, 0, st, en);
            else if (pick < 88) begin
                // Header that claims a length beyond any accepted frame.
                push_byte(ch, st);
                push_byte(ch, 8'($urandom_range(65, 127)));
                push_byte(ch, 8'h00);
            end
            else push_byte(ch, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        for (int c = 0; c < NCH; c++) begin
            mirror_fill[c] = 0;
            for (int i = 0; i < DEPTH; i++) mirror_buf[c][i] = 8'd0;
        end
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed cases: good frames, short and long lengths, bad end, junk.
        set_signs(8'hA5, 8'h5A, 7'd64);
        push_frame(0, 4, 1, 8'hA5, 8'h5A);
        push_frame(1, 5, 1, 8'hA5, 8'h5A);
        push_byte(0, 8'hA5); push_byte(0, 8'h03); push_byte(0, 8'h00);
        push_byte(0, 8'h5A);
        push_byte(1, 8'hA5); push_byte(1, 8'h41); push_byte(1, 8'h00);
        push_byte(1, 8'h5A);
        push_byte(0, 8'hA5); push_byte(0, 8'h04); push_byte(0, 8'h01);
        push_byte(0, 8'h5A);
        push_frame(1, 4, 0, 8'hA5, 8'h5A);
        push_byte(0, 8'hFF); push_byte(0, 8'h00);
        push_frame(0, 4, 1, 8'hA5, 8'h5A);
        drain();

        // Longest frame the buffer holds, after a short one on the other channel.
        push_frame(1, 6, 1, 8'hA5, 8'h5A);
        push_frame(0, 64, 1, 8'hA5, 8'h5A);
        drain();

        // Zero signs, smallest limit; receiver holds off while input fills.
        set_signs(8'h00, 8'h00, 7'd4);
        recv_stall_pct = 66;
        hold_req = 1;
        push_random(6, 8'h00, 8'h00, 4);
        drain();

        // All-ones signs, sender idles.
        set_signs(8'hFF, 8'hFF, 7'd64);
        recv_stall_pct = 0;
        send_idle_pct = 66;
        push_random(6, 8'hFF, 8'hFF, 64);
        drain();

        // Random settings, both sides idle.
        begin
            logic [7:0] st;
            logic [7:0] en;
            int mx;
            st = 8'($urandom_range(255));
            en = 8'($urandom_range(255));
            mx = $urandom_range(MINLEN, 64);
            set_signs(st, en, mx[6:0]);
            send_idle_pct = 25;
            recv_stall_pct = 25;
            push_random(6, st, en, mx);
        end
        drain();

        if (errors == 0 && expected_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/slde_pkg.sv
sv/slde_ctrl.sv
sv/slde_dp.sv
sv/sync_length_end_deframer.sv
tb/sv/sync_length_end_deframer_tb.sv
